// ===== hdl/asp_pkg.sv =====
// asp_pkg: shared types and constants for the as path validator
// used by asp_parser, asp_out_reg and as_path_validator; no dependencies
`default_nettype none
package asp_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_FOUR_BYTE_AS  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REJECT_AS_SET = 1'd1;

	localparam logic FOUR_BYTE_AS_RESET  = 1'b1;
	localparam logic REJECT_AS_SET_RESET = 1'b0;

	localparam logic [STATUS_W-1:0] ST_VALID = 3'd0;
	localparam logic [STATUS_W-1:0] ST_SOFT  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BAD   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_TYPE  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_LEN   = 3'd4;

	localparam logic [BYTE_W-1:0] SEG_AS_SET       = 8'd1;
	localparam logic [BYTE_W-1:0] SEG_AS_SEQUENCE  = 8'd2;
	localparam logic [BYTE_W-1:0] SEG_CONFED_SEQ   = 8'd3;
	localparam logic [BYTE_W-1:0] SEG_CONFED_SET   = 8'd4;

	typedef enum logic [1:0] {
		PH_TYPE  = 2'd0,
		PH_COUNT = 2'd1,
		PH_AS    = 2'd2
	} phase_t;

	typedef struct packed {
		logic                four_byte_as;
		logic                reject_as_set;
	} cfg_t;

endpackage
`default_nettype wire

// ===== hdl/asp_parser.sv =====
// asp_parser: per-byte as path parse state and end-of-path status
// depends on asp_pkg
`default_nettype none
module asp_parser (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            step,
	input  wire logic [asp_pkg::BYTE_W-1:0]      data_byte,
	input  wire logic                            is_last,
	input  wire logic                            empty_path,
	input  wire asp_pkg::cfg_t                   cfg,
	output logic                                 path_end,
	output logic [asp_pkg::STATUS_W-1:0]         status
);

	asp_pkg::phase_t               phase_q, phase_d;
	logic [asp_pkg::BYTE_W-1:0]    held_type_q, held_type_d;
	logic [asp_pkg::BYTE_W-1:0]    as_left_q, as_left_d;
	logic [1:0]                    as_byte_pos_q, as_byte_pos_d;
	logic                          as_is_zero_q, as_is_zero_d;
	logic                          length_odd_q, length_odd_d;
	logic                          soft_seen_q, soft_seen_d;
	logic [asp_pkg::STATUS_W-1:0]  first_hard_q, first_hard_d;
	logic [1:0]                    pos_inc;
	logic                          zero_now;
	logic                          as_done;
	logic [asp_pkg::BYTE_W-1:0]    left_dec;

	assign path_end = empty_path | is_last;
	assign pos_inc  = as_byte_pos_q + 2'd1;
	assign zero_now = as_is_zero_q & (data_byte == '0);
	assign as_done  = (pos_inc == 2'd0) | (~cfg.four_byte_as & (pos_inc >= 2'd2));
	assign left_dec = as_left_q - 8'd1;

	// take one byte
	always_comb begin
		phase_d       = phase_q;
		held_type_d   = held_type_q;
		as_left_d     = as_left_q;
		as_byte_pos_d = as_byte_pos_q;
		as_is_zero_d  = as_is_zero_q;
		length_odd_d  = length_odd_q;
		soft_seen_d   = soft_seen_q;
		first_hard_d  = first_hard_q;
		if (!empty_path) begin
			length_odd_d = ~length_odd_q;
			if (first_hard_q == asp_pkg::ST_VALID) begin
				case (phase_q)
					asp_pkg::PH_TYPE: begin
						held_type_d = data_byte;
						phase_d     = asp_pkg::PH_COUNT;
					end
					asp_pkg::PH_COUNT: begin
						if (data_byte == '0) begin
							first_hard_d = asp_pkg::ST_BAD;
						end else begin
							if (held_type_q inside {asp_pkg::SEG_CONFED_SEQ,
									asp_pkg::SEG_CONFED_SET})
								soft_seen_d = 1'b1;
							if (cfg.reject_as_set && held_type_q == asp_pkg::SEG_AS_SET)
								soft_seen_d = 1'b1;
							if (!(held_type_q inside {[asp_pkg::SEG_AS_SET:
									asp_pkg::SEG_CONFED_SET]})) begin
								first_hard_d = asp_pkg::ST_TYPE;
							end else begin
								as_left_d     = data_byte;
								as_byte_pos_d = 2'd0;
								as_is_zero_d  = 1'b1;
								phase_d       = asp_pkg::PH_AS;
							end
						end
					end
					default: begin
						if (as_done) begin
							if (zero_now)
								soft_seen_d = 1'b1;
							as_byte_pos_d = 2'd0;
							as_is_zero_d  = 1'b1;
							as_left_d     = left_dec;
							if (left_dec == '0)
								phase_d = asp_pkg::PH_TYPE;
						end else begin
							as_byte_pos_d = pos_inc;
							as_is_zero_d  = zero_now;
						end
					end
				endcase
			end
		end
	end

	// status of the path after this byte
	always_comb begin
		if (length_odd_d)
			status = asp_pkg::ST_BAD;
		else if (first_hard_d != asp_pkg::ST_VALID)
			status = first_hard_d;
		else if (phase_d == asp_pkg::PH_COUNT)
			status = asp_pkg::ST_BAD;
		else if (phase_d == asp_pkg::PH_AS)
			status = asp_pkg::ST_LEN;
		else if (soft_seen_d)
			status = asp_pkg::ST_SOFT;
		else
			status = asp_pkg::ST_VALID;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= asp_pkg::PH_TYPE;
			held_type_q   <= '0;
			as_left_q     <= '0;
			as_byte_pos_q <= '0;
			as_is_zero_q  <= 1'b1;
			length_odd_q  <= 1'b0;
			soft_seen_q   <= 1'b0;
			first_hard_q  <= asp_pkg::ST_VALID;
		end else if (step) begin
			if (path_end) begin
				phase_q       <= asp_pkg::PH_TYPE;
				held_type_q   <= '0;
				as_left_q     <= '0;
				as_byte_pos_q <= '0;
				as_is_zero_q  <= 1'b1;
				length_odd_q  <= 1'b0;
				soft_seen_q   <= 1'b0;
				first_hard_q  <= asp_pkg::ST_VALID;
			end else begin
				phase_q       <= phase_d;
				held_type_q   <= held_type_d;
				as_left_q     <= as_left_d;
				as_byte_pos_q <= as_byte_pos_d;
				as_is_zero_q  <= as_is_zero_d;
				length_odd_q  <= length_odd_d;
				soft_seen_q   <= soft_seen_d;
				first_hard_q  <= first_hard_d;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/asp_out_reg.sv =====
// asp_out_reg: result register holding one path status transaction
// depends on asp_pkg
`default_nettype none
module asp_out_reg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            load,
	input  wire logic [asp_pkg::STATUS_W-1:0]    status_in,
	output logic                                 room,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [asp_pkg::STATUS_W-1:0]         path_status
);

	logic                          valid_q;
	logic [asp_pkg::STATUS_W-1:0]  status_q;

	assign room        = ~valid_q | ~out_stall;
	assign out_valid   = valid_q;
	assign path_status = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			status_q <= status_in;
	end

endmodule
`default_nettype wire

// ===== hdl/as_path_validator.sv =====
// as_path_validator: top level, input register, parser and result register
// depends on asp_pkg, asp_parser, asp_out_reg
// out_valid follows the last byte through the input register and the result register
// throughput: one byte per cycle; only a held result with the last byte or an empty
// path marker of the next path waiting stalls the input
// reset: parse state cleared, four_byte_as set to 1, reject_as_set cleared
`default_nettype none
module as_path_validator (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [asp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [asp_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [asp_pkg::BYTE_W-1:0]        data_byte,
	input  wire logic                              is_last,
	input  wire logic                              empty_path,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [asp_pkg::STATUS_W-1:0]           path_status
);

	asp_pkg::cfg_t                 cfg_q;
	logic                          valid_s1;
	logic [asp_pkg::BYTE_W-1:0]    byte_s1;
	logic                          last_s1;
	logic                          empty_s1;
	logic                          room;
	logic                          adv;
	logic                          path_end;
	logic [asp_pkg::STATUS_W-1:0]  status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.four_byte_as  <= asp_pkg::FOUR_BYTE_AS_RESET;
			cfg_q.reject_as_set <= asp_pkg::REJECT_AS_SET_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				asp_pkg::REG_FOUR_BYTE_AS:  cfg_q.four_byte_as  <= cfg_data[0];
				asp_pkg::REG_REJECT_AS_SET: cfg_q.reject_as_set <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign adv      = ~path_end | room;
	assign in_stall = valid_s1 & ~adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1  <= data_byte;
			last_s1  <= is_last;
			empty_s1 <= empty_path;
		end
	end

	asp_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (valid_s1 & adv),
		.data_byte  (byte_s1),
		.is_last    (last_s1),
		.empty_path (empty_s1),
		.cfg        (cfg_q),
		.path_end   (path_end),
		.status     (status)
	);

	asp_out_reg u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (valid_s1 & path_end & room),
		.status_in   (status),
		.room        (room),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.path_status (path_status)
	);

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> path_status <= asp_pkg::ST_LEN)
		else $error("path status out of range");

	a_end_loads_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && path_end && !in_stall |=> out_valid)
		else $error("finished path gave no result");

	a_held_byte_kept: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && in_stall |=> valid_s1 && $stable(byte_s1) && $stable(last_s1))
		else $error("stalled byte lost");

	a_stall_needs_full_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with free result register");

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// tb_top: self-checking bench for as_path_validator, byte streams of AS paths in, one status out
// depends on asp_pkg and the as_path_validator rtl; a local path tracker predicts each status
// directed paths first, then random paths under all four register settings with random gaps
module tb_top;

	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		logic [asp_pkg::BYTE_W-1:0] data;
		logic                       last;
		logic                       empty;
	} byte_item_t;

	typedef logic [asp_pkg::BYTE_W-1:0] byte_q_t[$];

	logic                           clk;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [asp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [asp_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                           in_valid = 1'b0;
	logic                           in_stall;
	logic [asp_pkg::BYTE_W-1:0]     data_byte = '0;
	logic                           is_last = 1'b0;
	logic                           empty_path = 1'b0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic [asp_pkg::STATUS_W-1:0]   path_status;

	as_path_validator dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.is_last    (is_last),
		.empty_path (empty_path),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.path_status(path_status)
	);

	// path tracker state and register shadow
	asp_pkg::cfg_t              cfg_now = '{four_byte_as: asp_pkg::FOUR_BYTE_AS_RESET,
	                                        reject_as_set: asp_pkg::REJECT_AS_SET_RESET};
	asp_pkg::phase_t            phase;
	logic [asp_pkg::BYTE_W-1:0] cur_seg;
	logic [asp_pkg::BYTE_W-1:0] as_left;
	logic [1:0]                 as_pos;
	logic                       as_zero;
	logic                       odd_len;
	logic                       soft_hit;
	logic [asp_pkg::STATUS_W-1:0] hard_err;

	byte_item_t                   byte_feed[$];
	logic [asp_pkg::STATUS_W-1:0] status_due[$];
	byte_item_t          next_item;
	bit                  in_taken;
	int                  in_gap;
	int                  stall_left;
	int                  calm_in;
	int                  calm_out;
	int                  items_made;
	int                  bytes_sent;
	int                  paths_checked;
	int                  errors;
	int                  cycles;
	int                  status_count[0:4];

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic void clear_path();
		phase    = asp_pkg::PH_TYPE;
		cur_seg  = '0;
		as_left  = '0;
		as_pos   = '0;
		as_zero  = 1'b1;
		odd_len  = 1'b0;
		soft_hit = 1'b0;
		hard_err = asp_pkg::ST_VALID;
	endfunction

	// returns 1 when the transaction closes a path, with its status
	function automatic bit advance_path(input byte_item_t it,
			output logic [asp_pkg::STATUS_W-1:0] verdict);
		logic [2:0] as_size;
		as_size = cfg_now.four_byte_as ? 3'd4 : 3'd2;
		verdict = asp_pkg::ST_VALID;
		if (!it.empty) begin
			odd_len = ~odd_len;
			if (hard_err == asp_pkg::ST_VALID) begin
				case (phase)
				asp_pkg::PH_TYPE: begin
					cur_seg = it.data;
					phase = asp_pkg::PH_COUNT;
				end
				asp_pkg::PH_COUNT: begin
					if (it.data == '0) begin
						hard_err = asp_pkg::ST_BAD;
					end else begin
						if (cur_seg == asp_pkg::SEG_CONFED_SEQ ||
								cur_seg == asp_pkg::SEG_CONFED_SET)
							soft_hit = 1'b1;
						if (cfg_now.reject_as_set && cur_seg == asp_pkg::SEG_AS_SET)
							soft_hit = 1'b1;
						if (cur_seg < asp_pkg::SEG_AS_SET ||
								cur_seg > asp_pkg::SEG_CONFED_SET) begin
							hard_err = asp_pkg::ST_TYPE;
						end else begin
							as_left = it.data;
							as_pos  = 2'd0;
							as_zero = 1'b1;
							phase   = asp_pkg::PH_AS;
						end
					end
				end
				default: begin
					if (it.data != '0)
						as_zero = 1'b0;
					as_pos = as_pos + 2'd1;
					if (as_pos == 2'd0 || {1'b0, as_pos} >= as_size) begin
						if (as_zero)
							soft_hit = 1'b1;
						as_pos  = 2'd0;
						as_zero = 1'b1;
						as_left = as_left - 8'd1;
						if (as_left == '0)
							phase = asp_pkg::PH_TYPE;
					end
				end
				endcase
			end
			if (!it.last)
				return 1'b0;
		end
		if (odd_len)
			verdict = asp_pkg::ST_BAD;
		else if (hard_err != asp_pkg::ST_VALID)
			verdict = hard_err;
		else if (phase == asp_pkg::PH_COUNT)
			verdict = asp_pkg::ST_BAD;
		else if (phase == asp_pkg::PH_AS)
			verdict = asp_pkg::ST_LEN;
		else if (soft_hit)
			verdict = asp_pkg::ST_SOFT;
		clear_path();
		return 1'b1;
	endfunction

	// mostly no gap, sometimes short, rarely long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 8);
		return $urandom_range(20, 40);
	endfunction

	task automatic push_item(input logic [asp_pkg::BYTE_W-1:0] d, input logic last,
			input logic empty);
		byte_item_t it;
		it.data  = d;
		it.last  = last;
		it.empty = empty;
		byte_feed.push_back(it);
		items_made++;
	endtask

	task automatic push_seq(input byte_q_t seq, input bit close);
		foreach (seq[i])
			push_item(seq[i], close && (i == seq.size() - 1), 1'b0);
	endtask

	task automatic gen_path();
		byte_q_t                    body;
		int                         kind;
		int                         nseg;
		int                         cnt;
		int                         r;
		int                         as_size;
		bit                         all_zero;
		logic [asp_pkg::BYTE_W-1:0] seg;
		as_size = cfg_now.four_byte_as ? 4 : 2;
		kind = $urandom_range(0, 99);
		if (kind >= 92 && kind < 95) begin
			push_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
			return;
		end
		if (kind >= 95) begin
			repeat ($urandom_range(1, 10))
				body.push_back(8'($urandom_range(0, 255)));
		end else begin
			nseg = $urandom_range(1, 3);
			repeat (nseg) begin
				r = $urandom_range(0, 99);
				if (r < 4)
					seg = 8'($urandom_range(0, 255));
				else
					seg = 8'($urandom_range(asp_pkg::SEG_AS_SET, asp_pkg::SEG_CONFED_SET));
				r = $urandom_range(0, 99);
				if (r < 5)
					cnt = 0;
				else if (r < 9)
					cnt = $urandom_range(5, 255);
				else
					cnt = $urandom_range(1, 4);
				body.push_back(seg);
				body.push_back(cnt[7:0]);
				repeat ((cnt > 5) ? 5 : cnt) begin
					all_zero = ($urandom_range(0, 7) == 0);
					repeat (as_size) begin
						if (all_zero || $urandom_range(0, 3) == 0)
							body.push_back(8'h00);
						else
							body.push_back(8'($urandom_range(1, 255)));
					end
				end
			end
		end
		// broken paths: cut short or one extra byte
		if (kind >= 72 && kind < 80 && body.size() > 1)
			repeat ($urandom_range(1, body.size() - 1))
				void'(body.pop_back());
		if (kind >= 80 && kind < 86)
			body.push_back(8'($urandom_range(0, 255)));
		push_seq(body, !(kind >= 86 && kind < 92));
		if (kind >= 86 && kind < 92)
			push_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
	endtask

	task automatic wait_idle();
		do
			@(posedge clk);
		while (byte_feed.size() != 0 || in_valid);
		@(negedge clk);
		while (status_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [asp_pkg::CFG_IDX_W-1:0] idx,
			input logic [asp_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
		asp_pkg::REG_FOUR_BYTE_AS: begin
			cfg_now.four_byte_as = val[0];
		end
		asp_pkg::REG_REJECT_AS_SET: begin
			cfg_now.reject_as_set = val[0];
		end
		default: begin
		end
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_phase(input int n);
		int target;
		target = items_made + n;
		while (items_made < target)
			gen_path();
		wait_idle();
	endtask

	// input driver
	always @(negedge clk) begin
		if (calm_in > 0)
			calm_in--;
		else if ($urandom_range(0, 39) == 0)
			calm_in = $urandom_range(30, 100);
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_taken) begin
			// stalled transaction holds
		end else if (in_gap > 0) begin
			in_valid <= 1'b0;
			in_gap--;
		end else if (byte_feed.size() != 0) begin
			next_item = byte_feed.pop_front();
			in_valid   <= 1'b1;
			data_byte  <= next_item.data;
			is_last    <= next_item.last;
			empty_path <= next_item.empty;
			in_gap = (calm_in > 0) ? 0 : pick_gap();
		end else begin
			in_valid <= 1'b0;
		end
	end

	// result stall
	always @(negedge clk) begin
		if (calm_out > 0)
			calm_out--;
		else if ($urandom_range(0, 39) == 0)
			calm_out = $urandom_range(30, 100);
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			stall_left = (calm_out > 0) ? 0 : pick_gap();
			out_stall <= 1'b0;
		end
	end

	// monitor: predict on input transactions, check output transactions
	always @(posedge clk) begin
		byte_item_t                   seen;
		logic [asp_pkg::STATUS_W-1:0] verdict;
		logic [asp_pkg::STATUS_W-1:0] want;
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d transactions queued and %0d statuses due",
				$time, byte_feed.size(), status_due.size());
			$display("FAIL as_path_validator");
			$finish;
		end else begin
			in_taken = arst_n && in_valid && !in_stall;
			if (in_taken) begin
				bytes_sent++;
				seen.data  = data_byte;
				seen.last  = is_last;
				seen.empty = empty_path;
				if (advance_path(seen, verdict))
					status_due.push_back(verdict);
			end
			if (arst_n && out_valid && !out_stall) begin
				if (status_due.size() == 0) begin
					$display("%0t: unexpected status, expected none, got %0d", $time, path_status);
					errors++;
				end else begin
					want = status_due.pop_front();
					paths_checked++;
					status_count[want]++;
					if (path_status !== want) begin
						$display("%0t: path_status mismatch, expected %0d, got %0d",
							$time, want, path_status);
						errors++;
					end
				end
			end
		end
	end

	initial begin
		clear_path();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// empty path, last mark ignored
		push_item(8'hFF, 1'b1, 1'b1);
		// zero test only on the as bytes
		push_seq({asp_pkg::SEG_AS_SEQUENCE, 8'd1, 8'h00, 8'h00, 8'h00, 8'h01}, 1'b1);
		// unknown type zero
		push_seq({8'h00, 8'hFF}, 1'b1);
		// empty segment
		push_seq({asp_pkg::SEG_CONFED_SEQ, 8'h00}, 1'b1);
		// segment runs past the end
		push_seq({asp_pkg::SEG_AS_SET, 8'hFF, 8'h00, 8'h07}, 1'b1);
		// path left open across a size change
		push_seq({asp_pkg::SEG_AS_SEQUENCE, 8'd2, 8'h00, 8'h00, 8'h00}, 1'b0);
		wait_idle();
		write_reg(asp_pkg::REG_FOUR_BYTE_AS, 1'b0);
		push_seq({8'h00, 8'h00, 8'h05}, 1'b1);
		// confederation set closed by an empty path marker
		push_seq({asp_pkg::SEG_CONFED_SET, 8'd1, 8'h00, 8'h00}, 1'b0);
		push_item(8'hA5, 1'b0, 1'b1);
		run_phase(150);

		write_reg(asp_pkg::REG_REJECT_AS_SET, 1'b1);
		run_phase(150);
		write_reg(asp_pkg::REG_FOUR_BYTE_AS, 1'b1);
		run_phase(150);
		write_reg(asp_pkg::REG_REJECT_AS_SET, 1'b0);
		run_phase(150);

		$display("checked %0d path statuses from %0d byte transactions, all four register settings",
			paths_checked, bytes_sent);
		$display("statuses seen: valid %0d, soft %0d, encoding %0d, type %0d, overrun %0d",
			status_count[asp_pkg::ST_VALID], status_count[asp_pkg::ST_SOFT],
			status_count[asp_pkg::ST_BAD], status_count[asp_pkg::ST_TYPE],
			status_count[asp_pkg::ST_LEN]);
		if (errors == 0)
			$display("PASS as_path_validator");
		else
			$display("FAIL as_path_validator");
		$finish;
	end

endmodule
